@@ rtl/core/canseg_pkg.sv @@
// Package: shared types and constants for the CAN segment reassembler.
`timescale 1ns / 1ps
package canseg_pkg;
  localparam int StoreDepth = 64;
  localparam int StoreCap   = 64;
  localparam int QDepth     = 2;

  typedef enum logic [1:0] {
    POS_SINGLE = 2'd0,
    POS_FIRST  = 2'd1,
    POS_MIDDLE = 2'd2,
    POS_FINAL  = 2'd3
  } seg_pos_t;

  typedef struct packed {
    logic       append;
    logic       complete;
    logic [5:0] base;
    logic [3:0] len;
    logic [6:0] total;
    logic [7:0] src;
    logic [3:0] func;
    logic [63:0] data;
  } cmd_t;
endpackage

@@ rtl/core/canseg_front.sv @@
// Front end: filters frames, tracks reassembly state, issues store/emit commands.
`timescale 1ns / 1ps
module canseg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            station_id,
  input  logic                  push,
  output logic                  full,
  input  logic [28:0]           ext_id,
  input  logic [3:0]            frame_len,
  input  logic [63:0]           payload,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output canseg_pkg::cmd_t      cmd
);
  logic              active;
  logic [6:0]        last_seg;
  logic [6:0]        collected;
  canseg_pkg::cmd_t  q [canseg_pkg::QDepth];
  logic              rd_ptr, wr_ptr;
  logic [1:0]        count;

  logic [3:0]        len;
  logic [6:0]        seg;
  logic [1:0]        pos;
  logic [7:0]        dst;
  logic [7:0]        sum;
  logic              accept, in_order, fits, take, dst_ok;
  canseg_pkg::cmd_t  c;

  assign len  = (frame_len > 4'd8) ? 4'd8 : frame_len;
  assign seg  = ext_id[18:12];
  assign pos  = ext_id[20:19];
  assign dst  = ext_id[28:21];
  assign sum  = {1'b0, collected} + {4'd0, len};
  assign dst_ok   = (dst == station_id);
  assign in_order = active && ({1'b0, seg} == {1'b0, last_seg} + 8'd1);
  assign fits     = (sum <= 8'(canseg_pkg::StoreCap));
  assign full     = (count == 2'(canseg_pkg::QDepth));
  assign accept   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    c = '0;
    c.len  = len;
    c.src  = ext_id[7:0];
    c.func = ext_id[11:8];
    c.data = payload;
    take = 1'b0;
    case (pos)
      canseg_pkg::POS_SINGLE: begin
        take = dst_ok; c.append = 1'b1; c.complete = 1'b1; c.total = {3'd0, len};
      end
      canseg_pkg::POS_FIRST: begin
        take = dst_ok; c.append = 1'b1;
      end
      canseg_pkg::POS_MIDDLE, canseg_pkg::POS_FINAL: begin
        take = dst_ok && in_order && fits;
        c.append = 1'b1;
        c.base = collected[5:0];
        c.complete = (pos == canseg_pkg::POS_FINAL);
        c.total = sum[6:0];
      end
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0; last_seg <= '0; collected <= '0;
      rd_ptr <= 1'b0; wr_ptr <= 1'b0; count <= '0;
    end else begin
      if (accept && take) begin
        q[wr_ptr] <= c;
        wr_ptr <= ~wr_ptr;
        case (pos)
          canseg_pkg::POS_FIRST: begin
            active <= 1'b1; last_seg <= seg; collected <= {3'd0, len};
          end
          canseg_pkg::POS_MIDDLE: begin
            last_seg <= seg; collected <= sum[6:0];
          end
          canseg_pkg::POS_FINAL: begin
            active <= 1'b0; last_seg <= '0; collected <= '0;
          end
          default: active <= active;
        endcase
      end
      if (cmd_valid && cmd_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept && take} - {1'b0, cmd_valid && cmd_ready};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(canseg_pkg::QDepth)) else $error("queue overflow");
  a_collect_cap: assert property (@(posedge clk) disable iff (rst)
    collected <= 7'(canseg_pkg::StoreCap)) else $error("collected beyond cap");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> collected == 7'd0 && last_seg == 7'd0)
    else $error("state");
endmodule

@@ rtl/core/canseg_back.sv @@
// Back end: writes the message store and streams completed messages as chunks.
`timescale 1ns / 1ps
module canseg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  canseg_pkg::cmd_t cmd,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       source_id,
  output logic [3:0]       function_id,
  output logic [63:0]      chunk_data,
  output logic [3:0]       chunk_bytes,
  output logic [2:0]       chunk_index,
  output logic [6:0]       message_length,
  output logic             last_chunk
);
  // store kept as 8 rows of 8 bytes, one row read per cycle while the chunk output is not stalled
  logic [63:0] mem [8];
  logic        busy;
  logic [2:0]  k;
  logic [2:0]  nlast;
  logic [6:0]  total;
  logic [7:0]  src;
  logic [3:0]  func;
  logic        ovalid;
  logic        can_out;
  logic [6:0]  base;
  logic [6:0]  left;
  logic [3:0]  n;
  logic [63:0] mask;
  logic [63:0] row;

  // write: payload bytes land at base..base+len-1, spanning at most two rows
  logic [127:0] wdata, wmask, cur, merged;
  logic [2:0]   r0, r1;
  logic [5:0]   sh;

  assign r0 = cmd.base[5:3];
  assign r1 = r0 + 3'd1;
  assign sh = {cmd.base[2:0], 3'b000};
  assign wdata = {64'd0, cmd.data} << sh;
  assign wmask = {64'd0, (cmd.len == 4'd8) ? {64{1'b1}} :
                 ((64'd1 << {cmd.len[2:0], 3'b000}) - 64'd1)} << sh;
  assign cur = {mem[r1], mem[r0]};
  assign merged = (cur & ~wmask) | (wdata & wmask);

  assign can_out   = !ovalid || pop;
  assign cmd_ready = !busy;
  assign empty     = !ovalid;

  assign base = {1'b0, k, 3'b000};
  assign left = (total > base) ? total - base : 7'd0;
  assign n    = (left > 7'd8) ? 4'd8 : left[3:0];
  assign mask = (n == 4'd8) ? {64{1'b1}} : ((64'd1 << {n[2:0], 3'b000}) - 64'd1);
  assign row  = mem[k];

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.append) begin
      mem[r0] <= merged[63:0];
      if (r1 != 3'd0) mem[r1] <= merged[127:64];
    end
    if (busy && can_out) begin
      source_id      <= src;
      function_id    <= func;
      chunk_data     <= row & mask;
      chunk_bytes    <= n;
      chunk_index    <= k;
      message_length <= total;
      last_chunk     <= (k == nlast);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; ovalid <= 1'b0; k <= '0;
    end else begin
      if (pop && ovalid) ovalid <= 1'b0;
      if (busy && can_out) begin
        ovalid <= 1'b1;
        k <= k + 3'd1;
        if (k == nlast) busy <= 1'b0;
      end else if (cmd_valid && cmd_ready && cmd.complete) begin
        busy  <= 1'b1;
        k     <= '0;
        total <= cmd.total;
        nlast <= (cmd.total == 7'd0) ? 3'd0 : 3'(({1'b0, cmd.total} - 8'd1) >> 3);
        src   <= cmd.src;
        func  <= cmd.func;
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd_ready) else $error("command taken while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    busy && can_out && k == nlast |=> !busy) else $error("emit did not end");
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> total <= 7'(canseg_pkg::StoreCap)) else $error("length range");
endmodule

@@ rtl/core/can_segment_reassembler.sv @@
// Top level: CAN extended-id segmented message reassembler.
//  channel | handshake     | payload
//  config  | station_we    | station_wdata[7:0]
//  frame   | push / full   | ext_id, frame_len, payload
//  chunk   | pop / empty   | source_id, function_id, chunk_data, chunk_bytes,
//          |               | chunk_index, message_length, last_chunk
// A frame is taken when push is high and full is low; a two-entry command queue
// sits between the filter and the store/emit unit. A completing frame occupies
// the emit unit while it takes its command and emits its chunks (1..8).
// Reset (rst, synchronous) clears state; the store itself holds no reset value.
// Either side may stall independently; full rises when the queue is full.
`timescale 1ns / 1ps
module can_segment_reassembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        station_we,
  input  logic [7:0]  station_wdata,
  input  logic        push,
  output logic        full,
  input  logic [28:0] ext_id,
  input  logic [3:0]  frame_len,
  input  logic [63:0] payload,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  source_id,
  output logic [3:0]  function_id,
  output logic [63:0] chunk_data,
  output logic [3:0]  chunk_bytes,
  output logic [2:0]  chunk_index,
  output logic [6:0]  message_length,
  output logic        last_chunk
);
  logic [7:0]       station_id;
  logic             cmd_valid, cmd_ready;
  canseg_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) station_id <= '0;
    else if (station_we) station_id <= station_wdata;
  end

  canseg_front u_front (
    .clk, .rst, .station_id, .push, .full, .ext_id, .frame_len, .payload,
    .cmd_valid, .cmd_ready, .cmd
  );

  canseg_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .empty, .pop,
    .source_id, .function_id, .chunk_data, .chunk_bytes, .chunk_index,
    .message_length, .last_chunk
  );
endmodule
